/* sv/abre_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// abre_pkg: shared types and constants
// Widths, command codes and structs for the adaptive binary range encoder.
// ---------------------------------------------------------------------------
package abre_pkg;

  localparam int NUM_CONTEXTS   = 1024;
  localparam int PROB_BITS      = 11;
  localparam int RUN_COUNT_BITS = 16;
  localparam int CTX_BITS       = $clog2(NUM_CONTEXTS);

  localparam logic [PROB_BITS:0] PROB_ONE = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [PROB_BITS-1:0] PROB_HALF = {1'b1, {(PROB_BITS-1){1'b0}}};
  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};

  localparam logic [2:0] CMD_BIT    = 3'd0;
  localparam logic [2:0] CMD_BYPASS = 3'd1;
  localparam logic [2:0] CMD_FINISH = 3'd2;
  localparam logic [2:0] CMD_START  = 3'd3;
  localparam logic [2:0] CMD_LOAD   = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [9:0]  context_index;
    logic        bit_value;
    logic [31:0] bypass_value;
    logic [5:0]  bypass_length;
    logic [10:0] probability_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]                lead_byte;
    logic [RUN_COUNT_BITS-1:0] run_count;
    logic [7:0]                run_byte;
    logic                      last;
    logic                      run_overflow;
  } out_item_t;

  // Probability memory access from the coder.
  typedef struct packed {
    logic                 rd_en;
    logic [CTX_BITS-1:0]  rd_addr;
    logic                 wr_en;
    logic [CTX_BITS-1:0]  wr_addr;
    logic [PROB_BITS-1:0] wr_data;
  } prob_req_t;

endpackage
`default_nettype wire

/* sv/abre_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// abre_if: valid/ready channel
// Carries one beat of payload from a source to a sink.
// ---------------------------------------------------------------------------
interface abre_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/abre_prob_mem.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// abre_prob_mem: context probability memory
// One write and one registered read per cycle. After reset a clearing pass
// writes one half to every row, one row per cycle, with busy high until it
// is done.
// ---------------------------------------------------------------------------
module abre_prob_mem (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire abre_pkg::prob_req_t            req,
  output logic [abre_pkg::PROB_BITS-1:0]      rd_data,
  output logic                                busy
);

  logic [abre_pkg::PROB_BITS-1:0] mem [abre_pkg::NUM_CONTEXTS];
  logic [abre_pkg::PROB_BITS-1:0] mem_q;
  logic                           clearing;
  logic [abre_pkg::CTX_BITS-1:0]  clr_addr;

  // Storage array and registered read; the clearing pass owns the write port.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= abre_pkg::PROB_HALF;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  // Clearing pass over all rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == abre_pkg::CTX_BITS'(abre_pkg::NUM_CONTEXTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign rd_data = mem_q;
  assign busy    = clearing;

endmodule
`default_nettype wire

/* sv/abre_coder.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// abre_coder: range coder sequencer
// Runs one command at a time: probability read, multiply, update, then bypass
// bits one at a time and one byte shift per cycle while the output register can take a result.
// ---------------------------------------------------------------------------
module abre_coder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [3:0]                  adapt_shift,
  abre_if.sink                             in_ch,
  abre_if.source                           out_ch,
  output abre_pkg::prob_req_t              mreq,
  input  wire logic [abre_pkg::PROB_BITS-1:0] mrd,
  input  wire logic                        mem_busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_BYP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]  state;
  abre_pkg::in_item_t item;
  logic [32:0] low;
  logic [31:0] range;
  logic [7:0]  cache;
  logic [abre_pkg::RUN_COUNT_BITS-1:0] pending;
  logic        saturated;
  logic [abre_pkg::PROB_BITS-1:0] prob;
  logic        ctx_ok;
  logic [31:0] bound;
  logic [5:0]  bits_left;
  logic [2:0]  fin_left;
  logic        have_held;
  abre_pkg::out_item_t held;
  abre_pkg::out_item_t held_last;
  abre_pkg::out_item_t obuf;
  logic        obuf_valid;
  logic        obuf_load;
  logic        ctx_in_range;

  // Byte shift logic.
  logic        carry;
  logic        settle;
  logic [31:0] low32;
  abre_pkg::out_item_t shift_res;
  logic [3:0]  shift_amt;
  logic [abre_pkg::PROB_BITS-1:0] prob_new;
  logic        shift_go;
  logic        done_go;

  assign low32 = low[31:0];
  assign carry = low[32];
  assign settle = (low32 < 32'hFF00_0000) || carry;

  always_comb begin
    shift_res.lead_byte    = cache + {7'd0, carry};
    shift_res.run_count    = pending - 1'b1;
    shift_res.run_byte     = carry ? 8'h00 : 8'hFF;
    shift_res.last         = 1'b0;
    shift_res.run_overflow = saturated;
  end

  // The held result marked as the final one of its command.
  always_comb begin
    held_last      = held;
    held_last.last = 1'b1;
  end

  assign shift_amt = (adapt_shift == 4'd0) ? 4'd1 : adapt_shift;

  always_comb begin
    if (!item.bit_value) begin
      prob_new = prob + abre_pkg::PROB_BITS'((abre_pkg::PROB_ONE
                 - {1'b0, prob}) >> shift_amt);
    end else begin
      prob_new = prob - (prob >> shift_amt);
    end
  end

  assign ctx_in_range = {1'b0, in_ch.data.context_index}
                        < 11'(abre_pkg::NUM_CONTEXTS);

  // A shift may run only when the output register can take a result.
  assign shift_go = !have_held || !obuf_valid || out_ch.ready;

  assign in_ch.ready = (state == S_IDLE) && !mem_busy;
  assign out_ch.valid = obuf_valid;
  assign out_ch.data  = obuf;

  always_comb begin
    mreq.rd_en   = in_ch.valid && in_ch.ready;
    mreq.rd_addr = in_ch.data.context_index[abre_pkg::CTX_BITS-1:0];
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = item.context_index[abre_pkg::CTX_BITS-1:0];
    mreq.wr_data = prob_new;
    if (in_ch.valid && in_ch.ready && in_ch.data.command == abre_pkg::CMD_LOAD
        && ctx_in_range) begin
      mreq.wr_en   = 1'b1;
      mreq.wr_addr = in_ch.data.context_index[abre_pkg::CTX_BITS-1:0];
      mreq.wr_data = (in_ch.data.probability_value[abre_pkg::PROB_BITS-1:0] == '0)
                     ? abre_pkg::PROB_BITS'(1)
                     : in_ch.data.probability_value[abre_pkg::PROB_BITS-1:0];
    end else if (state == S_APPLY && ctx_ok) begin
      mreq.wr_en = 1'b1;
    end
  end

  // Is the current command out of work after this step?
  always_comb begin
    case (state)
      S_NORM:  done_go = (range >= 32'h0100_0000) && (bits_left == 6'd0);
      S_FIN:   done_go = (fin_left == 3'd1);
      default: done_go = 1'b0;
    endcase
  end

  // The held result moves to the output register on a settling shift or
  // when the command ends.
  always_comb begin
    obuf_load = 1'b0;
    if (have_held && shift_go) begin
      if (state == S_NORM && range >= 32'h0100_0000) begin
        obuf_load = (bits_left == 6'd0);
      end else if (state == S_NORM || state == S_FIN) begin
        obuf_load = settle;
      end
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (obuf_load) begin
      obuf_valid <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      obuf_valid <= 1'b0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low        <= '0;
      range      <= '1;
      cache      <= '0;
      pending    <= abre_pkg::RUN_COUNT_BITS'(1);
      saturated  <= 1'b0;
      have_held  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            ctx_ok <= ctx_in_range;
            bits_left <= (in_ch.data.bypass_length > 6'd32) ? 6'd32
                         : in_ch.data.bypass_length;
            fin_left <= 3'd5;
            case (in_ch.data.command)
              abre_pkg::CMD_BIT:    state <= S_READ;
              abre_pkg::CMD_BYPASS: state <= S_BYP;
              abre_pkg::CMD_FINISH: state <= S_FIN;
              abre_pkg::CMD_START: begin
                low       <= '0;
                range     <= '1;
                cache     <= '0;
                pending   <= abre_pkg::RUN_COUNT_BITS'(1);
                saturated <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          prob  <= mrd;
          state <= S_MUL;
        end
        S_MUL: begin
          bound <= 32'((range >> abre_pkg::PROB_BITS) * {21'd0, prob});
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (!item.bit_value) begin
            range <= bound;
          end else begin
            low   <= low + {1'b0, bound};
            range <= range - bound;
          end
          bits_left <= 6'd0;
          state <= S_NORM;
        end
        S_BYP: begin
          if (bits_left == 6'd0) begin
            state <= S_NORM;
          end else begin
            range <= range >> 1;
            if (item.bypass_value[bits_left[4:0] - 5'd1]) begin
              low <= low + {2'b0, range[31:1]};
            end
            bits_left <= bits_left - 6'd1;
            state <= S_NORM;
          end
        end
        S_NORM, S_FIN: begin
          if (state == S_NORM && range >= 32'h0100_0000) begin
            if (bits_left != 6'd0) begin
              state <= S_BYP;
            end else if (shift_go) begin
              // Flush the held result as the last one of the item.
              if (have_held) begin
                obuf      <= held_last;
                have_held <= 1'b0;
              end
              state <= S_IDLE;
            end
          end else if (shift_go) begin
            if (state == S_NORM) begin
              range <= range << 8;
            end
            if (settle) begin
              if (have_held) begin
                obuf <= held;
              end
              held      <= shift_res;
              have_held <= 1'b1;
              cache     <= low32[31:24];
              pending   <= abre_pkg::RUN_COUNT_BITS'(1);
              saturated <= 1'b0;
            end else if (pending == abre_pkg::RUN_MAX) begin
              saturated <= 1'b1;
            end else begin
              pending <= pending + 1'b1;
            end
            low <= {1'b0, low32[23:0], 8'd0};
            if (state == S_FIN) begin
              fin_left <= fin_left - 3'd1;
              if (done_go) begin
                state <= S_NORM;
                bits_left <= 6'd0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/adaptive_binary_range_encoder_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// adaptive_binary_range_encoder_top: LZMA-style binary range encoder
// Adaptive context probabilities in a memory, cache/carry byte output.
// ---------------------------------------------------------------------------
//  Channel  | Dir | Beat
//  in_ch    | in  | command, context, bit, bypass bits, probability
//  out_ch   | out | lead byte, run count, run byte, last, overflow
//  cfg_ch   | in  | adapt_shift (4 bits)
//
// A modeled bit passes through accept, memory read, multiply, update and
// check, then its byte shifts; bypass codes its bits one by one, each followed
// by a check and any shifts; finish shifts out the low register; start, load
// and unused codes are done at acceptance.
// Reset clears the coder state, then a pass over all 1024 rows sets all
// probabilities to one half while the input is held off.
// A full output register stalls byte shifts and the end of a command until
// the result is taken.
// ---------------------------------------------------------------------------
module adaptive_binary_range_encoder_top (
  input  wire logic clk,
  input  wire logic rst,
  abre_if.sink      in_ch,
  abre_if.source    out_ch,
  abre_if.sink      cfg_ch
);

  logic [3:0] adapt_shift;
  abre_pkg::prob_req_t mreq;
  logic [abre_pkg::PROB_BITS-1:0] mrd;
  logic mem_busy;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      adapt_shift <= 4'd5;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      adapt_shift <= cfg_ch.data[3:0];
    end
  end

  abre_prob_mem u_mem (.clk, .rst, .req(mreq), .rd_data(mrd), .busy(mem_busy));

  abre_coder u_coder (
    .clk, .rst, .adapt_shift, .in_ch, .out_ch, .mreq, .mrd, .mem_busy
  );

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output beat changed under stall");

  // A command that codes or shifts keeps the input closed on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready
      && (in_ch.data.command == abre_pkg::CMD_BIT
          || in_ch.data.command == abre_pkg::CMD_BYPASS
          || in_ch.data.command == abre_pkg::CMD_FINISH)
      |=> !in_ch.ready)
    else $error("coder accepted a beat while busy");

endmodule
`default_nettype wire

/* sim/abre_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// abre_checker: result predictor and scoreboard for the range encoder
// Watches the command, result and register channels, works out the bytes
// each accepted command must settle, and compares every result beat.
// ---------------------------------------------------------------------------
module abre_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire abre_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire abre_pkg::out_item_t out_data,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [3:0]          cfg_data,
  output int                       failures,
  output int                       bytes_pending,
  output int                       results_checked
);

  // Shadow copy of the coder state.
  logic [abre_pkg::PROB_BITS-1:0]      prob_mem [abre_pkg::NUM_CONTEXTS];
  logic [63:0]                         coder_low;
  logic [31:0]                         coder_width;
  logic [7:0]                          cache;
  logic [abre_pkg::RUN_COUNT_BITS-1:0] run_len;
  logic                                run_full;
  logic [3:0]                          rate_shift;

  abre_pkg::out_item_t settled_q [$];
  abre_pkg::out_item_t item_bytes [$];

  task automatic restart_coder();
    coder_low   = '0;
    coder_width = '1;
    cache       = '0;
    run_len     = 1;
    run_full    = 1'b0;
  endtask

  // One byte shift: settles the cached byte unless a carry is still possible.
  task automatic shift_out();
    logic [31:0] low32;
    logic        carry;
    abre_pkg::out_item_t r;
    low32 = coder_low[31:0];
    carry = coder_low[32];
    if (low32 < 32'hFF00_0000 || carry) begin
      if (item_bytes.size() < 5) begin
        r.lead_byte    = cache + 8'(carry);
        r.run_count    = run_len - 1'b1;
        r.run_byte     = 8'hFF + 8'(carry);
        r.last         = 1'b0;
        r.run_overflow = run_full;
        item_bytes.push_back(r);
      end
      cache    = low32[31:24];
      run_len  = '0;
      run_full = 1'b0;
    end
    if (run_len >= abre_pkg::RUN_MAX) run_full = 1'b1;
    else run_len = run_len + 1'b1;
    coder_low = {32'd0, low32[23:0], 8'd0};
  endtask

  task automatic renormalize();
    while (coder_width < 32'h0100_0000) begin
      coder_width = coder_width << 8;
      shift_out();
    end
  endtask

  // Works out the result beats of one accepted command.
  task automatic encode_command(input abre_pkg::in_item_t it);
    int unsigned p, s, bound, len, pv;
    item_bytes.delete();
    case (it.command)
      abre_pkg::CMD_BIT: begin
        p = prob_mem[it.context_index];
        s = (rate_shift == 0) ? 1 : rate_shift;
        bound = (coder_width >> abre_pkg::PROB_BITS) * p;
        if (!it.bit_value) begin
          coder_width = bound;
          p = p + (((1 << abre_pkg::PROB_BITS) - p) >> s);
        end else begin
          coder_low   = coder_low + bound;
          coder_width = coder_width - bound;
          p = p - (p >> s);
        end
        prob_mem[it.context_index] = p[abre_pkg::PROB_BITS-1:0];
        renormalize();
      end
      abre_pkg::CMD_BYPASS: begin
        len = (it.bypass_length > 32) ? 32 : it.bypass_length;
        for (int i = int'(len) - 1; i >= 0; i--) begin
          coder_width = coder_width >> 1;
          if (it.bypass_value[i]) coder_low = coder_low + coder_width;
          renormalize();
        end
      end
      abre_pkg::CMD_FINISH: begin
        for (int i = 0; i < 5; i++) shift_out();
      end
      abre_pkg::CMD_START: restart_coder();
      abre_pkg::CMD_LOAD: begin
        pv = it.probability_value & ((1 << abre_pkg::PROB_BITS) - 1);
        prob_mem[it.context_index] = (pv == 0) ? 1 : pv[abre_pkg::PROB_BITS-1:0];
      end
      default: ;
    endcase
    if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last = 1'b1;
    foreach (item_bytes[i]) settled_q.push_back(item_bytes[i]);
  endtask

  // Results are compared before the same edge's command is predicted, since
  // a command can never cause a beat at the edge it is accepted.
  always @(posedge clk) begin
    abre_pkg::out_item_t want;
    if (rst) begin
      foreach (prob_mem[i]) prob_mem[i] = abre_pkg::PROB_HALF;
      rate_shift = 4'd5;
      restart_coder();
      settled_q.delete();
      failures = 0;
      results_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (settled_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result beat lead %h run %0d byte %h last %b ovf %b",
                   $time, out_data.lead_byte, out_data.run_count, out_data.run_byte,
                   out_data.last, out_data.run_overflow);
        end else begin
          want = settled_q.pop_front();
          if (out_data !== want) begin
            failures++;
            $display("%0t: result mismatch: expected lead %h run %0d byte %h last %b ovf %b",
                     $time, want.lead_byte, want.run_count, want.run_byte, want.last,
                     want.run_overflow);
            $display("%0t:                  actual lead %h run %0d byte %h last %b ovf %b",
                     $time, out_data.lead_byte, out_data.run_count, out_data.run_byte,
                     out_data.last, out_data.run_overflow);
          end
        end
      end
      if (cfg_valid && cfg_ready) rate_shift = cfg_data;
      if (in_valid && in_ready) encode_command(in_data);
    end
    bytes_pending = settled_q.size();
  end

endmodule

/* sim/adaptive_binary_range_encoder_top_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// adaptive_binary_range_encoder_top_test: range encoder testbench
// Drives directed and randomized command streams with random gaps and
// output stalls, across several adaptation rates, and lets the checker
// compare every settled byte against its own model of the coder.
// ---------------------------------------------------------------------------
module adaptive_binary_range_encoder_top_test;

  logic clk = 1'b0;
  logic rst = 1'b1;

  abre_if #(.T(abre_pkg::in_item_t))  in_ch ();
  abre_if #(.T(abre_pkg::out_item_t)) out_ch ();
  abre_if #(.T(logic [3:0]))          cfg_ch ();

  int  failures, bytes_pending, results_checked;
  int  items_sent = 0;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  always #4 clk = ~clk;

  adaptive_binary_range_encoder_top uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  abre_checker scoreboard (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_data        (cfg_ch.data),
    .failures        (failures),
    .bytes_pending   (bytes_pending),
    .results_checked (results_checked)
  );

  // Sends one command beat, with an occasional idle burst in front of it.
  task automatic send_cmd(input abre_pkg::in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic make_cmd(input logic [2:0] op, output abre_pkg::in_item_t it);
    it.command           = op;
    it.context_index     = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 7));
    it.bit_value         = 1'($urandom);
    it.bypass_value      = $urandom;
    it.bypass_length     = $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(1, 32));
    it.probability_value = 11'($urandom);
  endtask

  task automatic send_op(input logic [2:0] op);
    abre_pkg::in_item_t it;
    make_cmd(op, it);
    send_cmd(it);
  endtask

  // Lets the encoder run dry before a register write.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_shift(input logic [3:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.data  = val;
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // One well-formed stream: start, a few loads, coded bits, finish.
  task automatic send_stream(input int n);
    send_op(abre_pkg::CMD_START);
    repeat ($urandom_range(0, 3)) send_op(abre_pkg::CMD_LOAD);
    repeat (n) send_op($urandom_range(0, 2) != 0 ? abre_pkg::CMD_BIT : abre_pkg::CMD_BYPASS);
    send_op(abre_pkg::CMD_FINISH);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #3_200_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    abre_pkg::in_item_t it;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: fastest adaptation, probability extremes, bypass lengths.
    write_shift(4'd1);
    make_cmd(abre_pkg::CMD_LOAD, it);
    it.context_index = 10'd1023; it.probability_value = 11'd2047; send_cmd(it);
    it.context_index = 10'd0;    it.probability_value = 11'd0;    send_cmd(it);
    it.context_index = 10'd1;    it.probability_value = 11'd1;    send_cmd(it);
    make_cmd(abre_pkg::CMD_BIT, it);
    it.context_index = 10'd0; it.bit_value = 1'b1; send_cmd(it);
    it.bit_value = 1'b0; send_cmd(it);
    it.context_index = 10'd1023; it.bit_value = 1'b1; send_cmd(it);
    it.bit_value = 1'b0; send_cmd(it);
    it.context_index = 10'd1; it.bit_value = 1'b1; send_cmd(it);
    make_cmd(abre_pkg::CMD_BYPASS, it);
    it.bypass_value = 32'hFFFF_FFFF; it.bypass_length = 6'd32; send_cmd(it);
    it.bypass_length = 6'd0;  send_cmd(it);
    it.bypass_length = 6'd63; send_cmd(it);
    it.bypass_value = 32'h0; it.bypass_length = 6'd33; send_cmd(it);
    it.bypass_length = 6'd1; send_cmd(it);
    for (int c = 5; c < 8; c++) send_op(3'(c));
    send_op(abre_pkg::CMD_FINISH);
    send_op(abre_pkg::CMD_START);
    send_op(abre_pkg::CMD_FINISH);
    drain();

    // Random streams at several adaptation rates, long output hold-off once.
    write_shift(4'd8);
    for (int k = 0; k < 4; k++) begin
      if (k == 1) hold_req = 1'b1;
      send_stream($urandom_range(6, 14));
      if ($urandom_range(0, 3) == 0) send_op(3'($urandom_range(5, 7)));
    end
    drain();
    write_shift(4'd0);
    send_stream(12);
    drain();
    write_shift(4'd15);
    send_stream(10);
    drain();
    write_shift(4'($urandom));
    gaps_on = 1'b0;
    send_stream(18);
    drain();

    $display("Sent %0d commands over five adaptation rates; %0d result beats compared.",
             items_sent, results_checked);
    if (failures == 0 && bytes_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
